@@ rtl/palette_index_builder_assert.svh @@
// assertion macros for the palette index builder
`ifndef PALETTE_INDEX_BUILDER_ASSERT_SVH
`define PALETTE_INDEX_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS

`define PIB_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("pib: forbidden condition seen");

`define PIB_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pib: implication failed");

`define PIB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pib: next-cycle implication failed");

`else

`define PIB_ASSERT_NEVER(label, expr)
`define PIB_ASSERT_IMPLY(label, ante, cons)
`define PIB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/pib_pkg.sv @@
// shared types and constants of the palette index builder
package pib_pkg;

    localparam int COLOR_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int NIBBLE_W   = 4;
    localparam int OUT_DATA_W = 2 * BYTE_W;
    localparam int OUT_USER_W = 3;

    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;

    // bit positions in the output tuser
    localparam int U_NEW_ENTRY    = 0;
    localparam int U_PALETTE_FULL = 1;
    localparam int U_BYTE_VALID   = 2;

    localparam logic MODE_CLUT8 = 1'b0;
    localparam logic MODE_CLUT4 = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic load;
        logic search;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/palette_index_builder.sv @@
// top level of the palette index builder
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata pixel_color, tlast last_pixel
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata index+byte, tuser flags, tlast
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_data clut_mode
//
//  the search reads the palette one entry at a time through the single read port;
//  a hit stops at its slot, a miss reads every entry, an empty palette none
//  the palette is empty after reset and after each last beat; no clearing pass
//  a finished result waits in the output register while the next pixel is taken
//  a result only waits in the emit state if the previous one is still untaken
module palette_index_builder #(
    parameter int PALETTE_DEPTH       = 256,
    parameter int SMALL_PALETTE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pib_pkg::COLOR_W-1:0]    s_axis_tdata,  // pixel_color
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pib_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // color_index, packed_byte
    output logic [pib_pkg::OUT_USER_W-1:0] m_axis_tuser,  // new_entry, palette_full, byte_valid
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data
);

`include "palette_index_builder_assert.svh"

    pib_pkg::t_cmd w_cmd;
    pib_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pib_datapath #(
        .PALETTE_DEPTH       (PALETTE_DEPTH),
        .SMALL_PALETTE_DEPTH (SMALL_PALETTE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_valid & o_cfg_ready),
        .i_cfg_mode (i_cfg_data),
        .i_color    (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready)
    );

    `PIB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PIB_ASSERT_NEVER(a_new_and_full, m_axis_tvalid && m_axis_tuser[pib_pkg::U_NEW_ENTRY] && m_axis_tuser[pib_pkg::U_PALETTE_FULL])
    `PIB_ASSERT_IMPLY(a_full_index_zero, m_axis_tvalid && m_axis_tuser[pib_pkg::U_PALETTE_FULL], m_axis_tdata[pib_pkg::BYTE_W-1:0] == '0)

endmodule

@@ rtl/pib_ctrl.sv @@
// controller state machine: accept, search, emit
module pib_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pib_pkg::t_sts i_sts,
    output pib_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_SEARCH;
                        r_in_ready <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    if (i_sts.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready   = r_in_ready;
    assign o_cmd.load   = r_in_ready & i_in_valid;
    assign o_cmd.search = (r_state == S_SEARCH);
    assign o_cmd.emit   = (r_state == S_EMIT) & i_sts.out_free;

endmodule

@@ rtl/pib_datapath.sv @@
// datapath: palette memory, search pipeline, nibble packer, output register
module pib_datapath #(
    parameter int PALETTE_DEPTH       = 256,
    parameter int SMALL_PALETTE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pib_pkg::t_cmd                     i_cmd,
    output pib_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_mode,
    input  logic [pib_pkg::COLOR_W-1:0]       i_color,
    input  logic                              i_last,
    output logic [pib_pkg::OUT_DATA_W-1:0]    o_tdata,
    output logic [pib_pkg::OUT_USER_W-1:0]    o_tuser,
    output logic                              o_tlast,
    output logic                              o_tvalid,
    input  logic                              i_tready
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CW-1:0] LIMIT_CLUT8 = CW'(PALETTE_DEPTH);
    localparam logic [CW-1:0] LIMIT_CLUT4 = CW'(SMALL_PALETTE_DEPTH);

    logic [pib_pkg::COLOR_W-1:0] r_mem [PALETTE_DEPTH];

    logic                          r_mode;
    logic [CW-1:0]                 r_count;
    logic [pib_pkg::NIBBLE_W-1:0]  r_hold;
    logic                          r_odd;
    logic [pib_pkg::COLOR_W-1:0]   r_color;
    logic                          r_last;
    logic [CW-1:0]                 r_rd_ptr;
    logic [pib_pkg::COLOR_W-1:0]   r_rd_data;
    logic [AW-1:0]                 r_cmp_ptr;
    logic                          r_cmp_vld;
    logic [AW-1:0]                 r_idx;
    logic                          r_found;

    logic [pib_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [pib_pkg::OUT_USER_W-1:0] r_out_user;
    logic                           r_out_last;
    logic                           r_out_vld;

    logic                         w_more;
    logic                         w_hit;
    logic                         w_end;
    logic                         w_done;
    logic                         w_issue;
    logic [CW-1:0]                w_limit;
    logic                         w_can_add;
    logic                         w_fresh;
    logic                         w_full;
    logic [AW-1:0]                w_idx;
    pib_pkg::t_byte               w_color_index;
    logic [pib_pkg::NIBBLE_W-1:0] w_nib;
    pib_pkg::t_byte               w_packed;
    logic                         w_bvalid;
    logic                         n_odd;
    logic [pib_pkg::NIBBLE_W-1:0] n_hold;

    // search: one read per cycle, each compared in the cycle after its read
    assign w_more  = (r_rd_ptr < r_count);
    assign w_hit   = r_cmp_vld & (r_rd_data == r_color);
    assign w_end   = ~r_cmp_vld & ~w_more;
    assign w_done  = w_hit | w_end;
    assign w_issue = i_cmd.search & ~w_done & w_more;

    assign o_sts.done     = w_done;
    assign o_sts.out_free = ~r_out_vld | i_tready;

    // append decision and index
    assign w_limit   = (r_mode == pib_pkg::MODE_CLUT4) ? LIMIT_CLUT4 : LIMIT_CLUT8;
    assign w_can_add = (r_count < w_limit);
    assign w_fresh   = ~r_found & w_can_add;
    assign w_full    = ~r_found & ~w_can_add;

    always_comb begin
        if (r_found) begin
            w_idx = r_idx;
        end else if (w_can_add) begin
            w_idx = r_count[AW-1:0];
        end else begin
            w_idx = '0;
        end
    end

    assign w_color_index = pib_pkg::t_byte'(w_idx);
    assign w_nib         = w_color_index[pib_pkg::NIBBLE_W-1:0] & pib_pkg::NIBBLE_MASK;

    // byte packing
    always_comb begin
        w_packed = '0;
        w_bvalid = 1'b0;
        n_odd    = 1'b0;
        n_hold   = '0;
        if (r_mode == pib_pkg::MODE_CLUT8) begin
            w_packed = w_color_index;
            w_bvalid = 1'b1;
        end else if (!r_odd) begin
            n_hold = w_nib;
            n_odd  = 1'b1;
            if (r_last) begin
                w_packed = {{pib_pkg::NIBBLE_W{1'b0}}, w_nib};
                w_bvalid = 1'b1;
            end
        end else begin
            w_packed = {w_nib, r_hold};
            w_bvalid = 1'b1;
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && w_fresh) begin
            r_mem[r_count[AW-1:0]] <= r_color;
        end
        r_rd_data <= r_mem[r_rd_ptr[AW-1:0]];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_color  <= i_color;
            r_last   <= i_last;
            r_rd_ptr <= '0;
        end else if (w_issue) begin
            r_rd_ptr <= r_rd_ptr + 1'b1;
        end
        r_cmp_ptr <= r_rd_ptr[AW-1:0];
        if (i_cmd.search && w_done) begin
            r_found <= w_hit;
            r_idx   <= r_cmp_ptr;
        end
        if (i_cmd.emit) begin
            r_out_data <= {w_packed, w_color_index};
            r_out_user[pib_pkg::U_NEW_ENTRY]    <= w_fresh;
            r_out_user[pib_pkg::U_PALETTE_FULL] <= w_full;
            r_out_user[pib_pkg::U_BYTE_VALID]   <= w_bvalid;
            r_out_last <= r_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= pib_pkg::MODE_CLUT8;
            r_count   <= '0;
            r_hold    <= '0;
            r_odd     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
            r_cmp_vld <= w_issue;
            if (i_cmd.emit) begin
                if (r_last) begin
                    r_count <= '0;
                    r_odd   <= 1'b0;
                    r_hold  <= '0;
                end else begin
                    if (w_fresh) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_odd  <= n_odd;
                    r_hold <= n_hold;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_user;
    assign o_tlast  = r_out_last;
    assign o_tvalid = r_out_vld;

endmodule
